// ===== src/pnm_pkg.sv =====
// ----------------------------------------------------------------------------
// pnm_pkg: shared types and codes for the PNM header parser
// Holds the transfer payload types, the result status codes and the byte
// values that the parser recognizes.
// ----------------------------------------------------------------------------
package pnm_pkg;

  // One byte of the file stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } byte_item_t;

  // One parse result.
  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  image_type;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_sample;
    logic [11:0] raster_offset;
  } result_item_t;

  // Result status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_MAGIC   = 4'd1;
  localparam logic [3:0] ST_BAD_TYPE    = 4'd2;
  localparam logic [3:0] ST_MISSING_NUM = 4'd3;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd4;
  localparam logic [3:0] ST_ZERO_WIDTH  = 4'd5;
  localparam logic [3:0] ST_ZERO_HEIGHT = 4'd6;
  localparam logic [3:0] ST_ZERO_MAXVAL = 4'd7;
  localparam logic [3:0] ST_TOO_LONG    = 4'd8;

  // Byte values.
  localparam logic [7:0] CH_P       = 8'd80;
  localparam logic [7:0] CH_HASH    = 8'd35;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_ONE     = 8'd49;
  localparam logic [7:0] CH_SIX     = 8'd54;

  // Largest sample value and the saturation mark of the accumulator.
  localparam logic [16:0] MAXVAL_LIMIT = 17'd65535;
  localparam logic [16:0] ACC_SAT      = 17'd65536;

  // Parameter defaults.
  localparam int DEF_DIM_BITS         = 16;
  localparam int DEF_MAX_HEADER_BYTES = 4095;

endpackage

// ===== src/pnm_header_parser.sv =====
// ----------------------------------------------------------------------------
// pnm_header_parser: Netpbm header parser, one byte per transfer
// Path: the byte that causes a result waits in the input register, and the
// result is registered in the result register before it is offered.
// Throughput: one byte per cycle, set by the state update; only
// a result held by result_stall stops the parse stage.
// Reset: clears the valids and the parser state; bytes are then ignored until
// one arrives with file_start set.
// ----------------------------------------------------------------------------
module pnm_header_parser
  import pnm_pkg::*;
#(
  parameter int DIM_BITS         = DEF_DIM_BITS,
  parameter int MAX_HEADER_BYTES = DEF_MAX_HEADER_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  // The pipeline has two registers. The input register catches each byte
  // transfer, so one new byte can be taken while a finished result still
  // waits downstream; after that byte_stall stays high until the result
  // leaves. The parse stage consumes the registered byte and
  // writes any result into the result register.
  logic         advance;
  logic         stage_valid;
  byte_item_t   stage_item;
  logic         step_en;
  logic         res_valid;
  result_item_t res_item;

  pnm_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_item   (byte_item),
    .byte_stall  (byte_stall),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // The parser state moves only when the byte can leave the input register,
  // which also guarantees room for any result it produces.
  assign step_en = stage_valid && advance;

  pnm_parse_core #(
    .DIM_BITS         (DIM_BITS),
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_parse_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_en),
    .step_item (stage_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  pnm_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_item     (res_item),
    .advance      (advance),
    .result_valid (result_valid),
    .result_item  (result_item),
    .result_stall (result_stall)
  );

`ifndef NO_ASSERTIONS
  // A successful header always carries a known type and nonzero sizes.
  a_ok_complete: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_item.status == ST_OK)) |->
      ((result_item.image_type != 3'd0) && (result_item.image_width != 16'd0) &&
       (result_item.image_height != 16'd0) && (result_item.max_sample != 16'd0)))
    else $error("ok result with missing header field");

  // An error result reports no maxval and no raster offset.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_item.status != ST_OK)) |->
      ((result_item.max_sample == 16'd0) && (result_item.raster_offset == 12'd0)))
    else $error("error result carries maxval or offset");

  // A result is only loaded from a byte that sat in the input register.
  a_res_from_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> $past(stage_valid))
    else $error("result appeared without a parsed byte");
`endif

endmodule

// ===== src/pnm_in_stage.sv =====
// ----------------------------------------------------------------------------
// pnm_in_stage: input register of the PNM header parser
// Captures one byte transfer and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
module pnm_in_stage
  import pnm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  byte_item_t byte_item,
  output logic       byte_stall,
  input  logic       advance,
  output logic       stage_valid,
  output byte_item_t stage_item
);

  logic load;

  // The register takes a new byte when it is empty or drains this cycle.
  assign byte_stall = stage_valid && !advance;
  assign load       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_item <= byte_item;
    end
  end

endmodule

// ===== src/pnm_parse_core.sv =====
// ----------------------------------------------------------------------------
// pnm_parse_core: header state and per-byte update
// Holds the parser state and computes its next value and any result from
// the byte in the input register.
// ----------------------------------------------------------------------------
module pnm_parse_core
  import pnm_pkg::*;
#(
  parameter int DIM_BITS         = DEF_DIM_BITS,
  parameter int MAX_HEADER_BYTES = DEF_MAX_HEADER_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step_en,
  input  byte_item_t   step_item,
  output logic         res_valid,
  output result_item_t res_item
);

  localparam int DIM_W    = (DIM_BITS >= 16) ? 16 : DIM_BITS;
  localparam int IDX_BITS = $clog2(MAX_HEADER_BYTES + 2);
  localparam logic [16:0]         DIM_LIMIT = 17'((1 << DIM_W) - 1);
  localparam logic [IDX_BITS-1:0] MAX_IDX   = IDX_BITS'(MAX_HEADER_BYTES);

  localparam logic [3:0] PH_WAIT       = 4'd0;
  localparam logic [3:0] PH_MAGIC      = 4'd1;
  localparam logic [3:0] PH_TYPE       = 4'd2;
  localparam logic [3:0] PH_WIDTH      = 4'd3;
  localparam logic [3:0] PH_WIDTH_RUN  = 4'd4;
  localparam logic [3:0] PH_HEIGHT     = 4'd5;
  localparam logic [3:0] PH_HEIGHT_RUN = 4'd6;
  localparam logic [3:0] PH_MAXV       = 4'd7;
  localparam logic [3:0] PH_MAXV_RUN   = 4'd8;
  localparam logic [3:0] PH_RASTER     = 4'd9;

  logic [3:0]          phase, phase_next;
  logic                in_comment, in_comment_next;
  logic                resume_number, resume_number_next;
  logic [16:0]         number_acc, number_acc_next;
  logic [2:0]          saved_type, saved_type_next;
  logic [DIM_W-1:0]    saved_width, saved_width_next;
  logic [DIM_W-1:0]    saved_height, saved_height_next;
  logic [IDX_BITS-1:0] byte_index, byte_index_next;

  logic [7:0]           b;
  logic                 is_digit, is_space, in_run, emit;
  logic [3:0]           num_base, st;
  logic [20:0]          prod;
  logic [15:0]          maxv;
  logic [IDX_BITS-1:0]  idx_cur;
  logic                 give_offset;
  logic [IDX_BITS+11:0] off_ext;
  logic [DIM_W+15:0]    wd_ext, ht_ext;

  assign b        = step_item.data_byte;
  assign is_digit = b inside {[CH_ZERO:CH_NINE]};
  assign is_space = b inside {CH_SPACE, [8'd9:8'd13]};

  always_comb begin
    phase_next         = phase;
    in_comment_next    = in_comment;
    resume_number_next = resume_number;
    number_acc_next    = number_acc;
    saved_type_next    = saved_type;
    saved_width_next   = saved_width;
    saved_height_next  = saved_height;
    byte_index_next    = byte_index;
    emit               = 1'b0;
    st                 = ST_OK;
    maxv               = '0;
    give_offset        = 1'b0;
    idx_cur            = byte_index;
    prod               = '0;

    // A file start drops all progress and begins a new header.
    if (step_item.file_start) begin
      phase_next         = PH_MAGIC;
      in_comment_next    = 1'b0;
      resume_number_next = 1'b0;
      number_acc_next    = '0;
      saved_type_next    = '0;
      saved_width_next   = '0;
      saved_height_next  = '0;
      byte_index_next    = '0;
    end

    case (phase_next)
      PH_WIDTH, PH_WIDTH_RUN:   num_base = PH_WIDTH;
      PH_HEIGHT, PH_HEIGHT_RUN: num_base = PH_HEIGHT;
      default:                  num_base = PH_MAXV;
    endcase
    in_run = phase_next inside {PH_WIDTH_RUN, PH_HEIGHT_RUN, PH_MAXV_RUN};

    if ((phase_next == PH_WAIT) || (phase_next > PH_RASTER)) begin
      phase_next = PH_WAIT;
    end else begin
      idx_cur         = byte_index_next;
      byte_index_next = idx_cur + 1'b1;
      if (phase_next == PH_RASTER) begin
        emit        = 1'b1;
        st          = ST_OK;
        maxv        = number_acc_next[15:0];
        give_offset = 1'b1;
      end else if (idx_cur >= MAX_IDX) begin
        emit = 1'b1;
        st   = ST_TOO_LONG;
      end else if (phase_next == PH_MAGIC) begin
        if (b != CH_P) begin
          emit = 1'b1;
          st   = ST_BAD_MAGIC;
        end else begin
          phase_next = PH_TYPE;
        end
      end else if (phase_next == PH_TYPE) begin
        if (!(b inside {[CH_ONE:CH_SIX]})) begin
          emit = 1'b1;
          st   = ST_BAD_TYPE;
        end else begin
          saved_type_next = b[2:0];
          phase_next      = PH_WIDTH;
        end
      end else if (in_comment_next) begin
        if (b == CH_NEWLINE) begin
          in_comment_next = 1'b0;
        end
      end else if (b == CH_HASH) begin
        // A comment breaks the digit run but keeps the digits seen so far.
        in_comment_next = 1'b1;
        phase_next      = num_base;
      end else if (is_digit) begin
        prod = ({4'd0, number_acc_next} << 3) + ({4'd0, number_acc_next} << 1) +
               21'(b[3:0]);
        number_acc_next    = (prod > 21'(MAXVAL_LIMIT)) ? ACC_SAT : prod[16:0];
        resume_number_next = 1'b1;
        phase_next         = num_base + 4'd1;
      end else if (!in_run && is_space) begin
        phase_next = phase_next;
      end else if (!resume_number_next) begin
        emit = 1'b1;
        st   = ST_MISSING_NUM;
      end else begin
        resume_number_next = 1'b0;
        case (num_base)
          PH_WIDTH: begin
            if (number_acc_next == '0) begin
              emit = 1'b1;
              st   = ST_ZERO_WIDTH;
            end else if (number_acc_next > DIM_LIMIT) begin
              emit = 1'b1;
              st   = ST_TOO_LARGE;
            end else begin
              saved_width_next = number_acc_next[DIM_W-1:0];
              number_acc_next  = '0;
              phase_next       = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (number_acc_next == '0) begin
              emit = 1'b1;
              st   = ST_ZERO_HEIGHT;
            end else if (number_acc_next > DIM_LIMIT) begin
              emit = 1'b1;
              st   = ST_TOO_LARGE;
            end else begin
              saved_height_next = number_acc_next[DIM_W-1:0];
              number_acc_next   = '0;
              phase_next        = PH_MAXV;
            end
          end
          default: begin
            if (number_acc_next == '0) begin
              emit = 1'b1;
              st   = ST_ZERO_MAXVAL;
            end else if (number_acc_next > MAXVAL_LIMIT) begin
              emit = 1'b1;
              st   = ST_TOO_LARGE;
            end else begin
              phase_next = PH_RASTER;
            end
          end
        endcase
      end
    end

    if (emit) begin
      phase_next = PH_WAIT;
    end
  end

  assign off_ext = {12'd0, idx_cur};
  assign wd_ext  = {16'd0, saved_width_next};
  assign ht_ext  = {16'd0, saved_height_next};

  assign res_valid = step_en && emit;

  always_comb begin
    res_item.status        = st;
    res_item.image_type    = saved_type_next;
    res_item.image_width   = wd_ext[15:0];
    res_item.image_height  = ht_ext[15:0];
    res_item.max_sample    = maxv;
    res_item.raster_offset = give_offset ? off_ext[11:0] : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      in_comment    <= 1'b0;
      resume_number <= 1'b0;
      number_acc    <= '0;
      saved_type    <= '0;
      saved_width   <= '0;
      saved_height  <= '0;
      byte_index    <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      in_comment    <= in_comment_next;
      resume_number <= resume_number_next;
      number_acc    <= number_acc_next;
      saved_type    <= saved_type_next;
      saved_width   <= saved_width_next;
      saved_height  <= saved_height_next;
      byte_index    <= byte_index_next;
    end
  end

endmodule

// ===== src/pnm_out_stage.sv =====
// ----------------------------------------------------------------------------
// pnm_out_stage: result register of the PNM header parser
// Holds one result until the downstream side takes it, and tells the
// pipeline when it may move.
// ----------------------------------------------------------------------------
module pnm_out_stage
  import pnm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  input  result_item_t res_item,
  output logic         advance,
  output logic         result_valid,
  output result_item_t result_item,
  input  logic         result_stall
);

  // The pipeline moves when the register is empty or is drained this cycle.
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      result_item <= res_item;
    end
  end

endmodule

// ===== tb/tb_pnm_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_pnm_header_parser: self-checking regression for the PNM header parser
// Feeds byte streams (hand-written headers, random well-formed headers with
// comments and joined digit runs, damaged and cut-off headers and loose
// noise) while both sides idle and stall at random. A scoreboard tracks the
// header grammar byte by byte and compares every result transfer field by
// field with its prediction.
// ----------------------------------------------------------------------------
module tb_pnm_header_parser;
  import pnm_pkg::*;

  // Whitespace runs from tab to carriage return, plus the space.
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam int unsigned DIM_LIMIT =
    (DEF_DIM_BITS >= 16) ? 65535 : ((1 << DEF_DIM_BITS) - 1);
  localparam int unsigned HEADER_LIMIT = DEF_MAX_HEADER_BYTES;

  localparam int BYTE_TARGET = 1150;
  // Longest correct stretch without any transfer is a send gap, or the pass
  // through the input and result registers plus a result stall; this is many times that.
  localparam int QUIET_LIMIT = 400;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MAGIC,
    PH_TYPE,
    PH_FIELD,
    PH_RASTER
  } parse_phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: follows the header grammar and holds the results still due.
  // --------------------------------------------------------------------------
  class header_scoreboard;
    parse_phase_t phase;
    int           field;       // 0 width, 1 height, 2 maxval
    bit           in_digits;   // the last byte of this number was a digit
    bit           in_comment;
    bit           have_digit;  // some digit of the current number was seen
    logic [16:0]  acc;
    logic [2:0]   img_type;
    logic [15:0]  width;
    logic [15:0]  height;
    logic [12:0]  index;
    result_item_t due_results[$];
    int           mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      phase      = PH_IDLE;
      field      = 0;
      in_digits  = 0;
      in_comment = 0;
      have_digit = 0;
      acc        = '0;
      img_type   = '0;
      width      = '0;
      height     = '0;
      index      = '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit is_space(logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function void close_header(logic [3:0] status, logic [15:0] maxv,
                               logic [11:0] offs);
      result_item_t r;
      r.status        = status;
      r.image_type    = img_type;
      r.image_width   = width;
      r.image_height  = height;
      r.max_sample    = maxv;
      r.raster_offset = offs;
      due_results = {due_results, r};
      phase = PH_IDLE;
    endfunction

    // Advances the parse by one accepted byte and queues any result it causes.
    function void take_byte(byte_item_t it);
      logic [7:0]  b;
      logic [12:0] idx;
      int unsigned grown;
      logic [16:0] v;
      b = it.data_byte;
      if (it.file_start) begin
        restart();
        phase = PH_MAGIC;
      end
      if (phase == PH_IDLE) return;
      idx   = index;
      index = idx + 13'd1;

      if (phase == PH_RASTER) begin
        close_header(ST_OK, acc[15:0], idx[11:0]);
        return;
      end
      if (idx >= HEADER_LIMIT) begin
        close_header(ST_TOO_LONG, '0, '0);
        return;
      end
      if (phase == PH_MAGIC) begin
        if (b != CH_P) close_header(ST_BAD_MAGIC, '0, '0);
        else phase = PH_TYPE;
        return;
      end
      if (phase == PH_TYPE) begin
        if (b < CH_ONE || b > CH_SIX) begin
          close_header(ST_BAD_TYPE, '0, '0);
        end else begin
          img_type = 3'(b - CH_ZERO);
          phase    = PH_FIELD;
        end
        return;
      end

      if (in_comment) begin
        if (b == CH_NEWLINE) in_comment = 0;
        return;
      end
      // A comment does not end a number; the digit run may go on after it.
      if (b == CH_HASH) begin
        in_comment = 1;
        in_digits  = 0;
        return;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        grown = acc;
        grown = grown * 10 + (b - CH_ZERO);
        acc = (grown > MAXVAL_LIMIT) ? ACC_SAT : grown[16:0];
        have_digit = 1;
        in_digits  = 1;
        return;
      end
      if (!in_digits && is_space(b)) return;

      // This byte ends the current number and is consumed.
      if (!have_digit) begin
        close_header(ST_MISSING_NUM, '0, '0);
        return;
      end
      have_digit = 0;
      in_digits  = 0;
      v = acc;
      case (field)
        0: begin
          if (v == 0) close_header(ST_ZERO_WIDTH, '0, '0);
          else if (v > DIM_LIMIT) close_header(ST_TOO_LARGE, '0, '0);
          else begin
            width = v[15:0];
            acc   = '0;
            field = 1;
          end
        end
        1: begin
          if (v == 0) close_header(ST_ZERO_HEIGHT, '0, '0);
          else if (v > DIM_LIMIT) close_header(ST_TOO_LARGE, '0, '0);
          else begin
            height = v[15:0];
            acc    = '0;
            field  = 2;
          end
        end
        default: begin
          if (v == 0) close_header(ST_ZERO_MAXVAL, '0, '0);
          else if (v > MAXVAL_LIMIT) close_header(ST_TOO_LARGE, '0, '0);
          else phase = PH_RASTER;
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_item_t got);
      result_item_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing due: %p", got));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.image_type !== want.image_type)
        report_mismatch($sformatf("image_type %0d, expected %0d",
                                  got.image_type, want.image_type));
      if (got.image_width !== want.image_width)
        report_mismatch($sformatf("image_width %0d, expected %0d",
                                  got.image_width, want.image_width));
      if (got.image_height !== want.image_height)
        report_mismatch($sformatf("image_height %0d, expected %0d",
                                  got.image_height, want.image_height));
      if (got.max_sample !== want.max_sample)
        report_mismatch($sformatf("max_sample %0d, expected %0d",
                                  got.max_sample, want.max_sample));
      if (got.raster_offset !== want.raster_offset)
        report_mismatch($sformatf("raster_offset %0d, expected %0d",
                                  got.raster_offset, want.raster_offset));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test.
  // --------------------------------------------------------------------------
  logic         clk;
  logic         rst;
  logic         byte_valid;
  logic         byte_stall;
  byte_item_t   byte_item;
  logic         result_valid;
  logic         result_stall;
  result_item_t result_item;

  pnm_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  header_scoreboard sb = new();

  logic [7:0] file_bytes[$];
  int         bytes_sent;
  bit         tx_burst;
  bit         rx_burst;
  bit         rx_taken;
  bit         rx_armed;
  int         rx_wait;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side. Each result draws its own stall length when it first shows
  // up; while no result is offered the stall toggles at random as noise.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result_item);
      rx_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : rx_drive
    logic hold;
    hold = 1'b0;
    if (rx_taken) begin
      rx_taken = 1'b0;
      rx_armed = 1'b0;
    end
    if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
    if (result_valid) begin
      if (!rx_armed) begin
        rx_armed = 1'b1;
        rx_wait  = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (rx_wait > 0) begin
        hold = 1'b1;
        rx_wait--;
      end
    end else begin
      hold = !rx_burst && ($urandom_range(0, 3) == 0);
    end
    result_stall <= hold;
  end

  // A run with no transfer at all for too long means the block is stuck.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("pnm_header_parser regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte side.
  // --------------------------------------------------------------------------
  // Offers one byte after a random gap and returns at the edge of its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int         gap;
    byte_item_t it;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    it.data_byte  = b;
    it.file_start = fs;
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_item  <= it;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.take_byte(it);
  endtask

  // Sends the buffered file; only its first byte carries file_start.
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == 0);
      bytes_sent++;
    end
    file_bytes.delete();
  endtask

  // Holds the byte side idle until every predicted result has been taken.
  task automatic drain_results();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic void append_byte(logic [7:0] c);
    file_bytes = {file_bytes, c};
  endfunction

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic void add_comment();
    logic [7:0] c;
    append_byte(CH_HASH);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_NEWLINE) c = CH_HASH;
      append_byte(c);
    end
    append_byte(CH_NEWLINE);
  endfunction

  function automatic void add_filler();
    if ($urandom_range(0, 3) == 0) add_comment();
    else append_byte(pick_space());
  endfunction

  // Mostly legal sizes, with the zero and saturation edges mixed in.
  function automatic int unsigned pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 9);
    if (r < 70) return $urandom_range(1, 999);
    if (r < 85) return $urandom_range(1, 65535);
    if (r < 88) return 65535;
    if (r < 90) return 65536;
    if (r < 94) return 0;
    return $urandom_range(65536, 999999);
  endfunction

  // One number: leading filler, digits (maybe split by a comment, maybe with
  // leading zeros) and the byte that ends it.
  function automatic void add_field(int unsigned value);
    logic [7:0]  digits[$];
    int unsigned v;
    int          split;
    logic [7:0]  ender;
    repeat ($urandom_range(0, 2)) add_filler();
    v = value;
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3)) digits.push_front(CH_ZERO);
    split = 0;
    if (digits.size() > 1 && $urandom_range(0, 5) == 0)
      split = $urandom_range(1, digits.size() - 1);
    for (int k = 0; k < digits.size(); k++) begin
      if (split > 0 && k == split) begin
        add_comment();
        repeat ($urandom_range(0, 1)) append_byte(pick_space());
      end
      append_byte(digits[k]);
    end
    ender = pick_space();
    if ($urandom_range(0, 9) == 0) begin
      do ender = 8'($urandom_range(0, 255));
      while ((ender >= CH_ZERO && ender <= CH_NINE) || ender == CH_HASH);
    end
    append_byte(ender);
  endfunction

  function automatic void build_header();
    file_bytes.delete();
    append_byte(CH_P);
    append_byte(CH_ONE + 8'($urandom_range(0, 5)));
    add_field(pick_number());
    add_field(pick_number());
    add_field(pick_number());
    append_byte(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int kind;
    int pos;
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_item    = '0;
    bytes_sent   = 0;
    tx_burst     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A loose byte before any file is ignored.
    send_byte("x", 1'b0);
    load_text("Q");    send_file();   // bad magic
    load_text("P7");   send_file();   // type digit out of range
    load_text("P3x");  send_file();   // number missing
    load_text("P10 "); send_file();   // zero width
    load_text("P5");   send_file();   // cut off; the next file restarts it
    // Width digits joined across a comment, then a full good header.
    load_text("P61#\n2 3 4 Z");
    send_file();
    drain_results();

    // Random part: mostly well-formed headers with random content.
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        build_header();
        send_file();
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 80) begin
        build_header();
        pos = $urandom_range(0, file_bytes.size() - 1);
        file_bytes[pos] = 8'($urandom_range(0, 255));
        send_file();
      end else if (kind < 88) begin
        build_header();
        pos = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > pos) void'(file_bytes.pop_back());
        send_file();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          bytes_sent++;
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("pnm_header_parser regression: pass");
    end else begin
      $display("pnm_header_parser regression: fail");
    end
    $finish;
  end

endmodule
